@@ hw/rtl/spjq_pkg.sv @@
// Shared types and constants for the sorted priority job queue.
// No dependencies; imported by the top level and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

package spjq_pkg;

    localparam int SPJQ_DEPTH = 128;

    typedef enum logic {
        FN_ENQ = 1'b0,
        FN_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DROP  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  pri;
        logic [31:0] id;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] job_id;
        logic [7:0]  pri;
        logic [31:0] payload;
        logic [7:0]  occupancy;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_priority_job_queue_top.sv @@
// Top level of the sorted priority job queue: stream ports, output register.
// Depends on spjq_pkg, spjq_ram and spjq_ctrl.
//
// Bounded priority queue of QUEUE_DEPTH jobs, lowest priority value served
// first, equal priorities in arrival order. Each request gives one result.
// A full-queue enqueue, an empty-queue dequeue and an enqueue into an empty
// queue are answered from idle; a dequeue reads the head entry first, and an
// enqueue into a non-empty queue has the sequencer walk the store from the
// tail, one entry per cycle through the single RAM read port and one priority
// compare, moving each larger entry up by one slot.
// A new request is taken only while the sequencer is idle and the output
// register is empty or hands over its result in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_job_queue_top
    import spjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPJQ_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // priority_req[7:0], payload[39:8]
    input  wire logic        i_s_axis_tuser,   // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // job_id, out_priority, out_payload, occupancy
    output logic [1:0]       o_m_axis_tuser    // status
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic          w_idle;
    logic          w_start;
    t_result       w_res;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;

    logic          r_out_valid;
    t_result       r_out;

    assign o_s_axis_tready = w_idle && (!r_out_valid || i_m_axis_tready);
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;

    spjq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_func    (t_func'(i_s_axis_tuser)),
        .i_pri     (i_s_axis_tdata[7:0]),
        .i_payload (i_s_axis_tdata[39:8]),
        .o_idle    (w_idle),
        .o_res     (w_res),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    spjq_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {r_out.occupancy, r_out.payload, r_out.pri, r_out.job_id};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_out_valid || i_m_axis_tready))
        else $error("result produced while output register still held");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |->
        (r_out.job_id == 32'd0 && r_out.occupancy == 8'd0 && r_out.payload == 32'd0))
        else $error("empty result carries nonzero fields");

    a_start_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_start && i_s_axis_tuser == FN_DEQ && r_out_valid == 1'b0 && w_res.valid == 1'b0)
        |=> !o_s_axis_tready)
        else $error("dequeue walk did not hold off new requests");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/spjq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spjq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/spjq_ctrl.sv @@
// Sequencer of the job queue: circular sorted store walk with one shared compare.
// Depends on spjq_pkg; drives the store RAM ports.
`timescale 1ns / 1ps
`default_nettype none

module spjq_ctrl
    import spjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPJQ_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_func         i_func,
    input  wire logic [7:0]    i_pri,
    input  wire logic [31:0]   i_payload,
    output logic               o_idle,
    output t_result            o_res,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output t_entry             o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  wire t_entry        i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_DEQ
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_next_id, n_next_id;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pos, n_pos;
    t_entry        r_new, n_new;

    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [CW+7:0] occ_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - AW'(1);
    endfunction

    assign tail_sum = (AW+1)'(r_head) + (AW+1)'(r_count) - (AW+1)'(1);
    assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign occ_ext  = {8'd0, n_count};
    assign o_idle   = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_new     = r_new;
        o_wr_en   = 1'b0;
        o_wr_addr = r_ptr;
        o_wr_data = r_new;
        o_rd_addr = r_ptr;
        o_res     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == FN_ENQ) begin
                        n_next_id = r_next_id + 32'd1;
                        n_new     = '{pri: i_pri, id: r_next_id, payload: i_payload};
                        o_res.job_id = r_next_id;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            o_res.valid  = 1'b1;
                            o_res.status = ST_DROP;
                        end else if (r_count == '0) begin
                            o_wr_en      = 1'b1;
                            o_wr_addr    = r_head;
                            o_wr_data    = n_new;
                            n_count      = CW'(1);
                            o_res.valid  = 1'b1;
                            o_res.status = ST_ENQ;
                        end else begin
                            n_ptr     = tail;
                            n_pos     = r_count;
                            o_rd_addr = tail;
                            n_state   = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            o_res.valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end else begin
                            o_rd_addr = r_head;
                            n_state   = S_DEQ;
                        end
                    end
                end
            end
            S_CMP: begin
                if (i_rd_data.pri > r_new.pri) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = f_inc(r_ptr);
                    o_wr_data = i_rd_data;
                    if (r_pos == CW'(1)) begin
                        n_state = S_INS;
                    end else begin
                        n_ptr     = f_dec(r_ptr);
                        o_rd_addr = f_dec(r_ptr);
                        n_pos     = r_pos - CW'(1);
                    end
                end else begin
                    o_wr_en      = 1'b1;
                    o_wr_addr    = f_inc(r_ptr);
                    n_count      = r_count + CW'(1);
                    o_res.valid  = 1'b1;
                    o_res.status = ST_ENQ;
                    o_res.job_id = r_new.id;
                    n_state      = S_IDLE;
                end
            end
            S_INS: begin
                o_wr_en      = 1'b1;
                n_count      = r_count + CW'(1);
                o_res.valid  = 1'b1;
                o_res.status = ST_ENQ;
                o_res.job_id = r_new.id;
                n_state      = S_IDLE;
            end
            S_DEQ: begin
                n_head        = f_inc(r_head);
                n_count       = r_count - CW'(1);
                o_res.valid   = 1'b1;
                o_res.status  = ST_DEQ;
                o_res.job_id  = i_rd_data.id;
                o_res.pri     = i_rd_data.pri;
                o_res.payload = i_rd_data.payload;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.occupancy = occ_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_next_id <= 32'd1;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
        r_ptr <= n_ptr;
        r_pos <= n_pos;
        r_new <= n_new;
    end

endmodule

`default_nettype wire
